// File: rtl/window3x3_median_gauss_filter_unit_defines.svh
// Assertion macros for the 3x3 window filter checker.
`ifndef WINDOW3X3_MEDIAN_GAUSS_FILTER_UNIT_DEFINES_SVH
`define WINDOW3X3_MEDIAN_GAUSS_FILTER_UNIT_DEFINES_SVH

// Clocked property, disabled while reset is asserted.
`define W3MG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Signal holds its value over the cycle after cond.
`define W3MG_ASSERT_HOLD(lbl, cond, sig, msg) \
	`W3MG_ASSERT(lbl, (cond) |=> $stable(sig), msg)

`endif

// File: rtl/w3mg_pkg.sv
// Types, codes and helper functions shared by the 3x3 window filter files.
package w3mg_pkg;

	localparam int PIX_W   = 8;
	localparam int TAPS    = 9;
	localparam int SUM_W   = 12;
	localparam int G_SHIFT = 4;

	typedef logic [PIX_W-1:0] pixel_t;
	typedef logic [SUM_W-1:0] gsum_t;

	typedef enum logic {
		MODE_MEDIAN = 1'b0,
		MODE_GAUSS  = 1'b1
	} filter_mode_t;

	typedef struct packed {
		pixel_t lo;
		pixel_t mid;
		pixel_t hi;
	} trio_t;

	function automatic trio_t sort3(input pixel_t a, input pixel_t b, input pixel_t c);
		trio_t  r;
		pixel_t l1;
		pixel_t h1;
		pixel_t h2;
		l1   = (a < b) ? a : b;
		h1   = (a < b) ? b : a;
		r.hi = (h1 < c) ? c : h1;
		h2   = (h1 < c) ? h1 : c;
		r.lo  = (l1 < h2) ? l1 : h2;
		r.mid = (l1 < h2) ? h2 : l1;
		return r;
	endfunction

endpackage

// File: rtl/window3x3_median_gauss_filter_unit.sv
// Top level of the 3x3 window filter: median of nine or 1-2-1 gaussian average.
//
// Use: one 3x3 window of 8-bit grey pixels goes in per transfer on the window
// channel (win_valid / win_stall); one filtered pixel comes out per transfer on
// the result channel (res_valid / res_stall). cfg_we with cfg_wdata sets the
// mode: 0 median, 1 gaussian; change it only while no window is in flight.
// A window goes to the input register, then its result to the result register
// that drives res_valid. Throughput: one window per cycle while res_stall is low,
// set by the single input and result registers around the sort and adder logic.
// A new window is taken while a result waits, as long as the input register
// is free; win_stall rises only when both registers hold data and res_stall
// is high. A stalled result holds its value.
// Reset (arst_n low) empties both registers and sets median mode.
module window3x3_median_gauss_filter_unit
	import w3mg_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cfg_we,
	input  logic   cfg_wdata,
	input  logic   win_valid,
	output logic   win_stall,
	input  pixel_t row0_col0,
	input  pixel_t row0_col1,
	input  pixel_t row0_col2,
	input  pixel_t row1_col0,
	input  pixel_t row1_col1,
	input  pixel_t row1_col2,
	input  pixel_t row2_col0,
	input  pixel_t row2_col1,
	input  pixel_t row2_col2,
	output logic   res_valid,
	input  logic   res_stall,
	output pixel_t filtered_value
);

	filter_mode_t mode_q;
	logic         valid_s1;
	logic         valid_s2;
	pixel_t       win_s1 [TAPS];
	pixel_t       value_s2;
	logic         adv_s1;
	logic         adv_s2;
	trio_t        r0, r1, r2;
	trio_t        lows, mids, highs, fin;
	gsum_t        gsum;
	pixel_t       result;

	assign adv_s2    = !valid_s2 || !res_stall;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign win_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_MEDIAN;
		end else if (cfg_we) begin
			mode_q <= filter_mode_t'(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= win_valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && win_valid) begin
			win_s1[0] <= row0_col0;
			win_s1[1] <= row0_col1;
			win_s1[2] <= row0_col2;
			win_s1[3] <= row1_col0;
			win_s1[4] <= row1_col1;
			win_s1[5] <= row1_col2;
			win_s1[6] <= row2_col0;
			win_s1[7] <= row2_col1;
			win_s1[8] <= row2_col2;
		end
		if (adv_s2 && valid_s1) value_s2 <= result;
	end

	// median: sort rows, then columns, then the anti-diagonal
	always_comb begin
		r0    = sort3(win_s1[0], win_s1[1], win_s1[2]);
		r1    = sort3(win_s1[3], win_s1[4], win_s1[5]);
		r2    = sort3(win_s1[6], win_s1[7], win_s1[8]);
		lows  = sort3(r0.lo, r1.lo, r2.lo);
		mids  = sort3(r0.mid, r1.mid, r2.mid);
		highs = sort3(r0.hi, r1.hi, r2.hi);
		fin   = sort3(lows.hi, mids.mid, highs.lo);
	end

	always_comb begin
		gsum = gsum_t'(win_s1[0]) + gsum_t'(win_s1[2])
		     + gsum_t'(win_s1[6]) + gsum_t'(win_s1[8])
		     + (gsum_t'(win_s1[1]) << 1) + (gsum_t'(win_s1[3]) << 1)
		     + (gsum_t'(win_s1[5]) << 1) + (gsum_t'(win_s1[7]) << 1)
		     + (gsum_t'(win_s1[4]) << 2);
	end

	always_comb begin
		case (mode_q)
			MODE_GAUSS:  result = gsum[G_SHIFT +: PIX_W];
			MODE_MEDIAN: result = fin.mid;
			default:     result = fin.mid;
		endcase
	end

	assign res_valid      = valid_s2;
	assign filtered_value = value_s2;

endmodule

// File: rtl/w3mg_checker.sv
// Port-level checker for the 3x3 window filter, with its bind.
`include "window3x3_median_gauss_filter_unit_defines.svh"

module w3mg_checker
	import w3mg_pkg::*;
(
	input logic   clk,
	input logic   arst_n,
	input logic   win_valid,
	input logic   win_stall,
	input logic   res_valid,
	input logic   res_stall,
	input pixel_t filtered_value
);

	`W3MG_ASSERT(a_res_valid_holds, res_valid && res_stall |=> res_valid, "result dropped while stalled")
	`W3MG_ASSERT_HOLD(a_res_value_holds, res_valid && res_stall, filtered_value, "stalled result changed")
	`W3MG_ASSERT(a_stall_only_when_full, win_stall |-> res_valid && res_stall, "window stalled with room")
	`W3MG_ASSERT(a_result_follows, win_valid && !win_stall |-> ##2 res_valid, "no result two cycles on")

endmodule

bind window3x3_median_gauss_filter_unit w3mg_checker u_w3mg_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.win_valid      (win_valid),
	.win_stall      (win_stall),
	.res_valid      (res_valid),
	.res_stall      (res_stall),
	.filtered_value (filtered_value)
);
